@@ src/pbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits decoder package
// Shared types and constants for the PackBits decoder controller and datapath.
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam int unsigned OUT_W     = 32;
    localparam int unsigned OUT_BYTES = 4;
    localparam int unsigned CNT_W     = 3;

    localparam logic [7:0] HDR_NOP = 8'd128;
    localparam logic [8:0] RUN_BASE = 9'd257;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2
    } t_phase;

    typedef struct packed {
        logic take;
        logic emit_lit;
        logic start_run;
        logic emit_chunk;
    } t_cmd;

    typedef struct packed {
        logic lit_active;
        logic rep_active;
        logic run_final;
    } t_status;

endpackage

@@ src/packbits_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits decoder core
// Decodes a PackBits byte stream into words of up to four decoded bytes.
// ----------------------------------------------------------------------------
// The input channel takes one packed byte per word, with an end of stream
// flag on the final byte. The output channel gives words of decoded bytes,
// first byte in bits 7:0, with a byte count and a flag on the last word
// caused by each input byte. Both channels use valid and stall.
// Header bytes give no output. A literal byte appears on the output in the
// cycle after it is accepted.
// A repeat byte starts a run of ceil(count / BYTES_PER_RESULT) words, up to
// 32 at the default width, that drains one word per cycle from the run
// register while the receiver does not stall; the input stalls while it drains.
// The output register frees itself in the cycle its word is taken, so words
// flow at one per cycle when the receiver does not stall. When it stalls,
// the output word holds and no new input byte is accepted.
// Reset returns the decoder to expecting a header and empties the output.
// ----------------------------------------------------------------------------
module packbits_decoder_core #(
    parameter int unsigned BYTES_PER_RESULT = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_packed_byte,
    input  logic                      i_end_of_stream,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [pbd_pkg::OUT_W-1:0] o_out_bytes,
    output logic [pbd_pkg::CNT_W-1:0] o_byte_count,
    output logic                      o_last_of_run
);

    pbd_pkg::t_cmd    w_cmd;
    pbd_pkg::t_status w_status;

    pbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    pbd_datapath #(
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_packed_byte   (i_packed_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_status        (w_status),
        .o_out_bytes     (o_out_bytes),
        .o_byte_count    (o_byte_count),
        .o_last_of_run   (o_last_of_run)
    );

    a_no_accept_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("Input accepted while the output word is stalled.");

    a_literal_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_lit |=> (o_out_valid && o_last_of_run))
        else $error("Literal byte did not reach the output.");

    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start_run |=> o_in_stall)
        else $error("Input accepted while a repeat run drains.");

endmodule

@@ src/pbd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits decoder controller
// Sequences input acceptance, literal output and the draining of repeat runs.
// ----------------------------------------------------------------------------
module pbd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_stall,
    input  pbd_pkg::t_status i_status,
    output pbd_pkg::t_cmd   o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_accept;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_accept   = (r_state == S_IDLE) && i_in_valid && w_out_free;

    always_comb begin
        o_cmd.take       = w_accept;
        o_cmd.emit_lit   = w_accept && i_status.lit_active;
        o_cmd.start_run  = w_accept && i_status.rep_active;
        o_cmd.emit_chunk = (r_state == S_RUN) && w_out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.start_run) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (o_cmd.emit_chunk && i_status.run_final) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.emit_lit || o_cmd.emit_chunk) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = !((r_state == S_IDLE) && w_out_free);
    assign o_out_valid = r_out_valid;

endmodule

@@ src/pbd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits decoder datapath
// Holds the header phase, the run byte and count, and the output word register.
// ----------------------------------------------------------------------------
module pbd_datapath #(
    parameter int unsigned BYTES_PER_RESULT = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pbd_pkg::t_cmd               i_cmd,
    input  logic [7:0]                  i_packed_byte,
    input  logic                        i_end_of_stream,
    output pbd_pkg::t_status            o_status,
    output logic [pbd_pkg::OUT_W-1:0]   o_out_bytes,
    output logic [pbd_pkg::CNT_W-1:0]   o_byte_count,
    output logic                        o_last_of_run
);

    localparam logic [7:0] BPR = 8'(BYTES_PER_RESULT);

    pbd_pkg::t_phase r_phase;
    pbd_pkg::t_phase n_phase;
    logic [7:0]      r_left;
    logic [7:0]      n_left;
    logic [7:0]      r_run_byte;
    logic [7:0]      r_run_left;
    logic [7:0]      w_cnt;
    logic [pbd_pkg::OUT_W-1:0] w_chunk;
    logic [pbd_pkg::OUT_W-1:0] r_out_bytes;
    logic [pbd_pkg::CNT_W-1:0] r_byte_count;
    logic            r_last;

    always_comb begin
        o_status.lit_active = (r_phase == pbd_pkg::PH_LITERAL) && (r_left != 8'd0);
        o_status.rep_active = (r_phase == pbd_pkg::PH_REPEAT) && (r_left != 8'd0);
        o_status.run_final  = (r_run_left <= BPR);
    end

    assign w_cnt = (r_run_left < BPR) ? r_run_left : BPR;

    always_comb begin
        for (int i = 0; i < pbd_pkg::OUT_BYTES; i++) begin
            w_chunk[8*i +: 8] = (8'(i) < w_cnt) ? r_run_byte : 8'd0;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        if (o_status.lit_active) begin
            n_left = r_left - 8'd1;
            if (r_left == 8'd1) begin
                n_phase = pbd_pkg::PH_HEADER;
            end
        end else if (o_status.rep_active) begin
            n_phase = pbd_pkg::PH_HEADER;
            n_left  = 8'd0;
        end else if (i_packed_byte < pbd_pkg::HDR_NOP) begin
            n_phase = pbd_pkg::PH_LITERAL;
            n_left  = i_packed_byte + 8'd1;
        end else if (i_packed_byte == pbd_pkg::HDR_NOP) begin
            n_phase = pbd_pkg::PH_HEADER;
            n_left  = 8'd0;
        end else begin
            n_phase = pbd_pkg::PH_REPEAT;
            n_left  = 8'(pbd_pkg::RUN_BASE - {1'b0, i_packed_byte});
        end
        if (i_end_of_stream) begin
            n_phase = pbd_pkg::PH_HEADER;
            n_left  = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pbd_pkg::PH_HEADER;
            r_left  <= 8'd0;
        end else if (i_cmd.take) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_run) begin
            r_run_byte <= i_packed_byte;
            r_run_left <= r_left;
        end else if (i_cmd.emit_chunk) begin
            r_run_left <= r_run_left - w_cnt;
        end

        if (i_cmd.emit_lit) begin
            r_out_bytes  <= {{(pbd_pkg::OUT_W-8){1'b0}}, i_packed_byte};
            r_byte_count <= pbd_pkg::CNT_W'(1);
            r_last       <= 1'b1;
        end else if (i_cmd.emit_chunk) begin
            r_out_bytes  <= w_chunk;
            r_byte_count <= w_cnt[pbd_pkg::CNT_W-1:0];
            r_last       <= o_status.run_final;
        end
    end

    assign o_out_bytes   = r_out_bytes;
    assign o_byte_count  = r_byte_count;
    assign o_last_of_run = r_last;

endmodule

@@ tb/packbits_decoder_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits decoder core testbench
// Drives packed byte streams into the decoder and checks every decoded word.
// ----------------------------------------------------------------------------
// A behavioral decoder follows each accepted packed byte and queues the
// words it must produce. A monitor compares each word taken from the output
// with the oldest queued one. Short directed streams cover the header
// extremes, the no-op header, runs of every tail length and the end of
// stream flag. Random streams of well-formed packets, cut streams and noise
// follow, with random gaps and stalls on both channels, one long receiver
// hold-off and one burst with no idling at all.
// ----------------------------------------------------------------------------
module packbits_decoder_core_test;

    localparam int RESULT_BYTES = 4;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [pbd_pkg::OUT_W-1:0] data;
        logic [pbd_pkg::CNT_W-1:0] count;
        logic                      last;
    } t_decoded_word;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic [7:0]                in_byte = 8'd0;
    logic                      in_eos = 1'b0;
    logic                      out_stall = 1'b0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic [pbd_pkg::OUT_W-1:0] o_out_bytes;
    logic [pbd_pkg::CNT_W-1:0] o_byte_count;
    logic                      o_last_of_run;

    t_decoded_word    pending_words[$];
    pbd_pkg::t_phase  dec_phase = pbd_pkg::PH_HEADER;
    logic [7:0]       dec_left = 8'd0;

    bit in_idle_on  = 1'b1;
    bit out_idle_on = 1'b1;
    int hold_cycles = 0;
    bit hold_active = 1'b0;

    int errors        = 0;
    int bytes_sent    = 0;
    int words_checked = 0;
    int lit_headers   = 0;
    int run_headers   = 0;
    int nop_headers   = 0;
    int stream_ends   = 0;

    packbits_decoder_core #(
        .BYTES_PER_RESULT(RESULT_BYTES)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_packed_byte  (in_byte),
        .i_end_of_stream(in_eos),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_out_bytes    (o_out_bytes),
        .o_byte_count   (o_byte_count),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] lit_header(input int n);
        return 8'(n - 1);
    endfunction

    function automatic logic [7:0] run_header(input int n);
        return 8'(pbd_pkg::RUN_BASE - 9'(n));
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eos);
        t_decoded_word w;
        int left;
        int cnt;
        if (dec_phase == pbd_pkg::PH_LITERAL && dec_left != 8'd0) begin
            w.data  = '0;
            w.data[7:0] = b;
            w.count = pbd_pkg::CNT_W'(1);
            w.last  = 1'b1;
            pending_words.push_back(w);
            dec_left = dec_left - 8'd1;
            if (dec_left == 8'd0) begin
                dec_phase = pbd_pkg::PH_HEADER;
            end
        end else if (dec_phase == pbd_pkg::PH_REPEAT && dec_left != 8'd0) begin
            left = int'(dec_left);
            while (left != 0) begin
                cnt = (left < RESULT_BYTES) ? left : RESULT_BYTES;
                w.data = '0;
                for (int i = 0; i < cnt && i < int'(pbd_pkg::OUT_BYTES); i++) begin
                    w.data[8*i +: 8] = b;
                end
                left   = left - cnt;
                w.count = pbd_pkg::CNT_W'(cnt);
                w.last  = (left == 0);
                pending_words.push_back(w);
            end
            dec_phase = pbd_pkg::PH_HEADER;
            dec_left  = 8'd0;
        end else if (b < pbd_pkg::HDR_NOP) begin
            dec_phase = pbd_pkg::PH_LITERAL;
            dec_left  = b + 8'd1;
            lit_headers++;
        end else if (b == pbd_pkg::HDR_NOP) begin
            dec_phase = pbd_pkg::PH_HEADER;
            dec_left  = 8'd0;
            nop_headers++;
        end else begin
            dec_phase = pbd_pkg::PH_REPEAT;
            dec_left  = 8'(pbd_pkg::RUN_BASE - {1'b0, b});
            run_headers++;
        end
        if (eos) begin
            dec_phase = pbd_pkg::PH_HEADER;
            dec_left  = 8'd0;
            stream_ends++;
        end
    endfunction

    function automatic void check_word();
        t_decoded_word want;
        if (pending_words.size() == 0) begin
            $display("%0t: expected no word, actual bytes=%h count=%0d last=%b", $time,
                     o_out_bytes, o_byte_count, o_last_of_run);
            errors++;
            return;
        end
        want = pending_words.pop_front();
        words_checked++;
        if (o_out_bytes !== want.data) begin
            $display("%0t: out_bytes expected %h, actual %h", $time, want.data, o_out_bytes);
            errors++;
        end
        if (o_byte_count !== want.count) begin
            $display("%0t: byte_count expected %0d, actual %0d", $time, want.count,
                     o_byte_count);
            errors++;
        end
        if (o_last_of_run !== want.last) begin
            $display("%0t: last_of_run expected %b, actual %b", $time, want.last,
                     o_last_of_run);
            errors++;
        end
    endfunction

    // Prediction runs before the check so that the order within a time step
    // never matters.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !o_in_stall) begin
                decode_byte(in_byte, in_eos);
            end
            if (o_out_valid && !out_stall) begin
                check_word();
            end
        end
    end

    initial begin
        int busy;
        int free;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                out_stall   <= 1'b1;
                hold_active = 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                hold_active = 1'b0;
                out_stall   <= 1'b0;
            end else if (out_idle_on) begin
                busy = idle_length();
                if (busy != 0) begin
                    out_stall <= 1'b1;
                    repeat (busy) @(posedge clk);
                end
                out_stall <= 1'b0;
                free = $urandom_range(0, 5);
                repeat (free) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = in_idle_on ? idle_length() : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_eos   <= eos;
        do @(posedge clk); while (o_in_stall);
        bytes_sent++;
    endtask

    task automatic wait_drain();
        int n;
        in_valid <= 1'b0;
        n = 0;
        while (pending_words.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge clk);
            n++;
        end
        if (pending_words.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, pending_words.size());
            errors++;
            pending_words.delete();
        end
    endtask

    task automatic send_packet(input bit last_pkt, input bit cut);
        logic [7:0] seq[$];
        int kind;
        int len;
        int r;
        int cut_at;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            r = $urandom_range(0, 99);
            if (r < 80) len = $urandom_range(1, 6);
            else if (r < 96) len = $urandom_range(7, 40);
            else len = $urandom_range(100, 128);
            seq.push_back(lit_header(len));
            repeat (len) seq.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 9) begin
            seq.push_back(8'($urandom_range(129, 255)));
            seq.push_back(8'($urandom_range(0, 255)));
        end else begin
            seq.push_back(pbd_pkg::HDR_NOP);
        end
        cut_at = seq.size() - 1;
        if (cut) cut_at = $urandom_range(0, seq.size() - 1);
        for (int i = 0; i <= cut_at; i++) begin
            send_byte(seq[i], last_pkt && i == cut_at);
        end
    endtask

    task automatic send_streams(input int n_bytes);
        int target;
        int npk;
        bit cut;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            npk = $urandom_range(1, 5);
            cut = ($urandom_range(0, 9) == 0);
            for (int p = 0; p < npk; p++) begin
                send_packet(p == npk - 1, cut && p == npk - 1);
            end
        end
    endtask

    task automatic test_literals();
        send_byte(pbd_pkg::HDR_NOP, 1'b0);
        send_byte(lit_header(1), 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(lit_header(2), 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        wait_drain();
    endtask

    task automatic test_runs();
        send_byte(run_header(128), 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(run_header(2), 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(run_header(3), 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(run_header(5), 1'b0);
        send_byte(8'hC3, 1'b0);
        wait_drain();
    endtask

    task automatic test_stream_end();
        // A long literal packet cut short by the end flag, then the flag
        // on a header, on a finishing literal and on a repeat byte.
        send_byte(lit_header(128), 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b1);
        send_byte(run_header(4), 1'b1);
        send_byte(pbd_pkg::HDR_NOP, 1'b0);
        send_byte(lit_header(1), 1'b0);
        send_byte(8'h99, 1'b1);
        send_byte(run_header(17), 1'b0);
        send_byte(8'h77, 1'b1);
        wait_drain();
    endtask

    task automatic test_back_pressure();
        in_idle_on  = 1'b0;
        hold_cycles = HOLD_CYCLES;
        wait (hold_active);
        for (int i = 0; i < 6; i++) begin
            send_byte(run_header(128 - i), 8'($urandom_range(0, 255)) == 8'd0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(lit_header(1), 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        in_idle_on = 1'b1;
        wait_drain();
    endtask

    task automatic test_random_streams(input int n_bytes);
        send_streams(n_bytes);
        wait_drain();
    endtask

    task automatic test_noise(input int n_bytes);
        repeat (n_bytes) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
        send_byte(pbd_pkg::HDR_NOP, 1'b1);
        wait_drain();
    endtask

    task automatic test_no_idle(input int n_bytes);
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        send_streams(n_bytes);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        wait_drain();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_literals();
        test_runs();
        test_stream_end();
        test_back_pressure();
        test_random_streams(160);
        test_noise(40);
        test_no_idle(40);
        test_random_streams(100);
        wait_drain();
        repeat (40) @(posedge clk);
        if (pending_words.size() != 0) begin
            $display("%0t: %0d expected words left over", $time, pending_words.size());
            errors++;
        end
        $display("Decoded %0d packed bytes into %0d checked words: %0d literal packets,",
                 bytes_sent, words_checked, lit_headers);
        $display("%0d repeat runs, %0d no-op headers and %0d stream ends.",
                 run_headers, nop_headers, stream_ends);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("Timed out with %0d words still expected", pending_words.size());
        $display("FAILURE");
        $finish;
    end

endmodule
